/* rtl/smeu_pkg.sv */
// Shared constants, operation codes and types of the stack machine execute unit.
// No dependencies; every rtl file refers to it by scoped names.
package smeu_pkg;

    // Store sizes and the widths that follow from them
    localparam int ST_DEPTH = 1024;
    localparam int ST_AW    = $clog2(ST_DEPTH);
    localparam int CNT_W    = ST_AW + 1;
    localparam int LC_DEPTH = 4096;
    localparam int LC_AW    = $clog2(LC_DEPTH);
    localparam int USED_W   = LC_AW + 1;
    localparam int FR_DEPTH = 256;
    localparam int FR_AW    = $clog2(FR_DEPTH);
    localparam int FCNT_W   = FR_AW + 1;

    // Field widths of one beat
    localparam int OP_W   = 6;
    localparam int DATA_W = 64;
    localparam int SLOT_W = 8;
    localparam int ERR_W  = 4;
    localparam int IN_W   = 88;
    localparam int OUT_W  = 80;

    // Operation codes
    localparam logic [OP_W-1:0] OP_NOP    = 6'd0;
    localparam logic [OP_W-1:0] OP_DROP   = 6'd1;
    localparam logic [OP_W-1:0] OP_DUP    = 6'd2;
    localparam logic [OP_W-1:0] OP_SWAP   = 6'd3;
    localparam logic [OP_W-1:0] OP_OVER   = 6'd4;
    localparam logic [OP_W-1:0] OP_ROT    = 6'd5;
    localparam logic [OP_W-1:0] OP_ADD    = 6'd6;
    localparam logic [OP_W-1:0] OP_SUB    = 6'd7;
    localparam logic [OP_W-1:0] OP_MUL    = 6'd8;
    localparam logic [OP_W-1:0] OP_DIV    = 6'd9;
    localparam logic [OP_W-1:0] OP_REM    = 6'd10;
    localparam logic [OP_W-1:0] OP_AND    = 6'd11;
    localparam logic [OP_W-1:0] OP_OR     = 6'd12;
    localparam logic [OP_W-1:0] OP_XOR    = 6'd13;
    localparam logic [OP_W-1:0] OP_NOT    = 6'd14;
    localparam logic [OP_W-1:0] OP_BNOT   = 6'd15;
    localparam logic [OP_W-1:0] OP_SHL    = 6'd16;
    localparam logic [OP_W-1:0] OP_SHR    = 6'd17;
    localparam logic [OP_W-1:0] OP_EQ     = 6'd18;
    localparam logic [OP_W-1:0] OP_NE     = 6'd19;
    localparam logic [OP_W-1:0] OP_LT     = 6'd20;
    localparam logic [OP_W-1:0] OP_LE     = 6'd21;
    localparam logic [OP_W-1:0] OP_GT     = 6'd22;
    localparam logic [OP_W-1:0] OP_GE     = 6'd23;
    localparam logic [OP_W-1:0] OP_LDL    = 6'd24;
    localparam logic [OP_W-1:0] OP_STL    = 6'd25;
    localparam logic [OP_W-1:0] OP_PUSHF  = 6'd26;
    localparam logic [OP_W-1:0] OP_POPF   = 6'd27;
    localparam logic [OP_W-1:0] OP_PI8    = 6'd28;
    localparam logic [OP_W-1:0] OP_PI16   = 6'd29;
    localparam logic [OP_W-1:0] OP_PI32   = 6'd30;
    localparam logic [OP_W-1:0] OP_PI64   = 6'd31;
    localparam logic [OP_W-1:0] OP_PSTR   = 6'd32;
    localparam logic [OP_W-1:0] OP_JMP    = 6'd33;
    localparam logic [OP_W-1:0] OP_JZ     = 6'd34;
    localparam logic [OP_W-1:0] OP_JNZ    = 6'd35;
    localparam logic [OP_W-1:0] OP_TRAP   = 6'd36;
    localparam logic [OP_W-1:0] OP_ENTER  = 6'd37;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE   = 4'd0;
    localparam logic [ERR_W-1:0] ERR_OVER   = 4'd1;
    localparam logic [ERR_W-1:0] ERR_UNDER  = 4'd2;
    localparam logic [ERR_W-1:0] ERR_DIVZ   = 4'd3;
    localparam logic [ERR_W-1:0] ERR_LOCAL  = 4'd4;
    localparam logic [ERR_W-1:0] ERR_FRAMES = 4'd5;
    localparam logic [ERR_W-1:0] ERR_LOCALS = 4'd6;
    localparam logic [ERR_W-1:0] ERR_TRAP   = 4'd7;
    localparam logic [ERR_W-1:0] ERR_BADOP  = 4'd8;

    // One frame table entry
    typedef struct packed {
        logic [USED_W-1:0] base;
        logic [SLOT_W-1:0] slots;
    } t_frame;

endpackage

/* rtl/stack_machine_execute_unit.sv */
// Stack machine execute unit: sequencer, operand/local/frame memories, shared adder.
// Depends on smeu_pkg.
//
// One instruction per input beat, one result beat per instruction. The unit is busy
// from acceptance until its result is loaded into the output register; the result
// register lets the next instruction be taken while a result still waits. Stack
// shuffles, pushes, compares and logic: each extra stack operand costs one
// registered read of the operand stack memory, and a pop costs one more read to
// refresh the cached top. Multiply and divide/remainder run through one shared
// 65-bit adder one bit per cycle. Frame push and enter clear one local per cycle,
// and enter then moves the arguments one at a time. Memories reset to no defined
// contents.
module stack_machine_execute_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [5:0] operation, [69:6] immediate, [77:70] slot, [85:78] arg_count, [87:86] zero
    input  logic [smeu_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // [63:0] top_value, [74:64] stack_depth, [75] branch_taken, [79:76] error_code
    output logic [smeu_pkg::OUT_W-1:0] o_m_axis_tdata
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_EXEC = 5'd1;
    localparam logic [4:0] S_SWAP = 5'd2;
    localparam logic [4:0] S_SWP2 = 5'd3;
    localparam logic [4:0] S_OVER = 5'd4;
    localparam logic [4:0] S_ROT1 = 5'd5;
    localparam logic [4:0] S_ROT2 = 5'd6;
    localparam logic [4:0] S_ROT3 = 5'd7;
    localparam logic [4:0] S_ROT4 = 5'd8;
    localparam logic [4:0] S_BINW = 5'd9;
    localparam logic [4:0] S_MUL  = 5'd10;
    localparam logic [4:0] S_DNB  = 5'd11;
    localparam logic [4:0] S_DNA  = 5'd12;
    localparam logic [4:0] S_DIV  = 5'd13;
    localparam logic [4:0] S_DFX  = 5'd14;
    localparam logic [4:0] S_FIN  = 5'd15;
    localparam logic [4:0] S_LOC  = 5'd16;
    localparam logic [4:0] S_LDW  = 5'd17;
    localparam logic [4:0] S_ZERO = 5'd18;
    localparam logic [4:0] S_ENAR = 5'd19;
    localparam logic [4:0] S_ENW  = 5'd20;
    localparam logic [4:0] S_TOSW = 5'd21;
    localparam logic [4:0] S_OUT  = 5'd22;

    localparam int DW = smeu_pkg::DATA_W;
    localparam int AW = smeu_pkg::ST_AW;
    localparam int CW = smeu_pkg::CNT_W;
    localparam int LW = smeu_pkg::LC_AW;
    localparam int UW = smeu_pkg::USED_W;
    localparam int FW = smeu_pkg::FR_AW;
    localparam int NW = smeu_pkg::FCNT_W;
    localparam int SW = smeu_pkg::SLOT_W;

    localparam logic [CW-1:0] STK_FULL = CW'(smeu_pkg::ST_DEPTH);
    localparam logic [NW-1:0] FRM_FULL = NW'(smeu_pkg::FR_DEPTH);
    localparam logic [UW:0]   LOC_FULL = (UW+1)'(smeu_pkg::LC_DEPTH);

    // Sequencer and architectural state
    logic [4:0]                      r_state, n_state;
    logic [smeu_pkg::OP_W-1:0]       r_op, n_op;
    logic [DW-1:0]                   r_imm, n_imm;
    logic [SW-1:0]                   r_slot, n_slot;
    logic [SW-1:0]                   r_argc, n_argc;
    logic [CW-1:0]                   r_cnt, n_cnt;
    logic [NW-1:0]                   r_fcnt, n_fcnt;
    logic [UW-1:0]                   r_used, n_used;
    logic [smeu_pkg::ERR_W-1:0]      r_err, n_err;
    logic                            r_br, n_br;
    logic [DW-1:0]                   r_tos, n_tos;
    logic [DW-1:0]                   r_b, n_b;
    logic [DW-1:0]                   r_c, n_c;
    logic [DW-1:0]                   r_acc, n_acc;
    logic [DW-1:0]                   r_p, n_p;
    logic [DW-1:0]                   r_q, n_q;
    logic                            r_sa, n_sa;
    logic                            r_sb, n_sb;
    logic [SW-1:0]                   r_k, n_k;
    logic [UW-1:0]                   r_zb, n_zb;
    logic                            r_mval, n_mval;
    logic [smeu_pkg::OUT_W-1:0]      r_mdata, n_mdata;

    // Memories and their ports
    logic [DW-1:0]           st_mem [smeu_pkg::ST_DEPTH];
    logic [DW-1:0]           lc_mem [smeu_pkg::LC_DEPTH];
    smeu_pkg::t_frame        fr_mem [smeu_pkg::FR_DEPTH];
    logic [DW-1:0]           r_st_q;
    logic [DW-1:0]           r_lc_q;
    smeu_pkg::t_frame        r_fr_q;
    logic                    st_we, lc_we, fr_we;
    logic [AW-1:0]           st_wa, st_ra;
    logic [DW-1:0]           st_wd;
    logic [LW-1:0]           lc_wa, lc_ra;
    logic [DW-1:0]           lc_wd;
    logic [FW-1:0]           fr_wa, fr_ra;
    smeu_pkg::t_frame        fr_wd;

    // Shared adder
    logic [DW:0]   add_x, add_y;
    logic          add_sub;
    logic [DW+1:0] add_s;

    logic [CW-1:0] cm1, cm2, cm3;
    logic [UW:0]   loc_need;
    logic [UW-1:0] loc_addr;
    logic [DW-1:0] bin_res, dfx_val, push_val;
    logic          dfx_neg, s_acc;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_mval;
    assign o_m_axis_tdata  = r_mdata;

    assign cm1 = r_cnt - CW'(1);
    assign cm2 = r_cnt - CW'(2);
    assign cm3 = r_cnt - CW'(3);
    assign loc_need = {1'b0, r_used} + (UW+1)'(r_slot);
    assign loc_addr = r_fr_q.base + UW'(r_slot);

    assign add_s = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (DW+2)'(add_sub);

    // Route the shared adder
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (r_state)
            S_BINW: begin
                add_x   = {1'b0, r_st_q};
                add_y   = {1'b0, r_tos};
                add_sub = (r_op == smeu_pkg::OP_SUB);
            end
            S_MUL: begin
                add_x = {1'b0, r_acc};
                add_y = r_q[0] ? {1'b0, r_p} : '0;
            end
            S_DNB: begin
                add_y   = {1'b0, r_b};
                add_sub = 1'b1;
            end
            S_DNA: begin
                add_y   = {1'b0, r_tos};
                add_sub = 1'b1;
            end
            S_DIV: begin
                add_x   = {r_acc, r_p[DW-1]};
                add_y   = {1'b0, r_q};
                add_sub = 1'b1;
            end
            S_DFX: begin
                add_y   = {1'b0, dfx_val};
                add_sub = 1'b1;
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
    end

    // Simple two-operand results: second entry is left operand, top is right
    always_comb begin
        case (r_op)
            smeu_pkg::OP_AND: bin_res = r_st_q & r_tos;
            smeu_pkg::OP_OR:  bin_res = r_st_q | r_tos;
            smeu_pkg::OP_XOR: bin_res = r_st_q ^ r_tos;
            smeu_pkg::OP_SHL: bin_res = r_st_q << r_tos[5:0];
            smeu_pkg::OP_SHR: bin_res = DW'($signed(r_st_q) >>> r_tos[5:0]);
            smeu_pkg::OP_EQ:  bin_res = DW'(r_st_q == r_tos);
            smeu_pkg::OP_NE:  bin_res = DW'(r_st_q != r_tos);
            smeu_pkg::OP_LT:  bin_res = DW'($signed(r_st_q) < $signed(r_tos));
            smeu_pkg::OP_LE:  bin_res = DW'($signed(r_st_q) <= $signed(r_tos));
            smeu_pkg::OP_GT:  bin_res = DW'($signed(r_st_q) > $signed(r_tos));
            smeu_pkg::OP_GE:  bin_res = DW'($signed(r_st_q) >= $signed(r_tos));
            default:          bin_res = add_s[DW-1:0];
        endcase
    end

    // Divide fixup and push immediates
    always_comb begin
        dfx_val = (r_op == smeu_pkg::OP_DIV) ? r_p : r_acc;
        dfx_neg = (r_op == smeu_pkg::OP_DIV) ? (r_sa ^ r_sb) : r_sb;
        case (r_op)
            smeu_pkg::OP_PI8:  push_val = {{(DW-8){r_imm[7]}}, r_imm[7:0]};
            smeu_pkg::OP_PI16: push_val = {{(DW-16){r_imm[15]}}, r_imm[15:0]};
            smeu_pkg::OP_PI32: push_val = {{(DW-32){r_imm[31]}}, r_imm[31:0]};
            smeu_pkg::OP_PSTR: push_val = {{(DW-16){1'b0}}, r_imm[15:0]};
            default:           push_val = r_imm;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;  n_op = r_op;     n_imm = r_imm;   n_slot = r_slot;
        n_argc  = r_argc;   n_cnt = r_cnt;   n_fcnt = r_fcnt; n_used = r_used;
        n_err   = r_err;    n_br = r_br;     n_tos = r_tos;   n_b = r_b;
        n_c     = r_c;      n_acc = r_acc;   n_p = r_p;       n_q = r_q;
        n_sa    = r_sa;     n_sb = r_sb;     n_k = r_k;       n_zb = r_zb;
        n_mval  = r_mval;   n_mdata = r_mdata;
        st_we = 1'b0; st_wa = r_cnt[AW-1:0]; st_wd = r_tos; st_ra = cm2[AW-1:0];
        lc_we = 1'b0; lc_wa = '0; lc_wd = '0; lc_ra = loc_addr[LW-1:0];
        fr_we = 1'b0; fr_wa = r_fcnt[FW-1:0]; fr_ra = cm1[FW-1:0];
        fr_wd.base  = r_used;
        fr_wd.slots = r_slot;
        if (r_fcnt != '0) begin
            fr_ra = FW'(r_fcnt - NW'(1));
        end

        // Drop the output beat once taken
        if (r_mval && i_m_axis_tready) begin
            n_mval = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_op    = i_s_axis_tdata[5:0];
                    n_imm   = i_s_axis_tdata[69:6];
                    n_slot  = i_s_axis_tdata[77:70];
                    n_argc  = i_s_axis_tdata[85:78];
                    n_br    = 1'b0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                if (r_op == smeu_pkg::OP_ENTER) begin
                    // Reset error and frames, open frame zero, clear its locals, then move arguments
                    n_err       = smeu_pkg::ERR_NONE;
                    n_fcnt      = NW'(1);
                    n_used      = UW'(r_slot);
                    fr_we       = 1'b1;
                    fr_wa       = '0;
                    fr_wd.base  = '0;
                    n_zb        = '0;
                    n_k         = '0;
                    if (r_slot != '0) begin
                        n_state = S_ZERO;
                    end else if (r_argc != '0) begin
                        n_k     = r_argc;
                        n_state = S_ENAR;
                    end
                end else if (r_err == smeu_pkg::ERR_NONE) begin
                    case (r_op)
                        smeu_pkg::OP_NOP: begin
                            n_state = S_OUT;
                        end
                        smeu_pkg::OP_DROP, smeu_pkg::OP_JZ, smeu_pkg::OP_JNZ: begin
                            if (r_cnt == '0) begin
                                n_err = smeu_pkg::ERR_UNDER;
                            end else begin
                                if (r_op == smeu_pkg::OP_JZ) n_br = (r_tos == '0);
                                if (r_op == smeu_pkg::OP_JNZ) n_br = (r_tos != '0);
                                n_cnt = cm1;
                                if (r_cnt > CW'(1)) n_state = S_TOSW;
                            end
                        end
                        smeu_pkg::OP_DUP: begin
                            if (r_cnt == '0) begin
                                n_err = smeu_pkg::ERR_UNDER;
                            end else if (r_cnt == STK_FULL) begin
                                n_err = smeu_pkg::ERR_OVER;
                            end else begin
                                st_we = 1'b1;
                                n_cnt = r_cnt + CW'(1);
                            end
                        end
                        smeu_pkg::OP_SWAP: begin
                            if (r_cnt < CW'(2)) n_err = smeu_pkg::ERR_UNDER;
                            else n_state = S_SWAP;
                        end
                        smeu_pkg::OP_OVER: begin
                            if (r_cnt < CW'(2)) n_err = smeu_pkg::ERR_UNDER;
                            else if (r_cnt == STK_FULL) n_err = smeu_pkg::ERR_OVER;
                            else n_state = S_OVER;
                        end
                        smeu_pkg::OP_ROT: begin
                            if (r_cnt < CW'(3)) n_err = smeu_pkg::ERR_UNDER;
                            else n_state = S_ROT1;
                        end
                        smeu_pkg::OP_NOT, smeu_pkg::OP_BNOT: begin
                            if (r_cnt == '0) begin
                                n_err = smeu_pkg::ERR_UNDER;
                            end else begin
                                n_tos = (r_op == smeu_pkg::OP_NOT) ? DW'(r_tos == '0) : ~r_tos;
                                st_we = 1'b1;
                                st_wa = cm1[AW-1:0];
                                st_wd = (r_op == smeu_pkg::OP_NOT) ? DW'(r_tos == '0) : ~r_tos;
                            end
                        end
                        smeu_pkg::OP_LDL, smeu_pkg::OP_POPF: begin
                            if (r_fcnt != '0) n_state = S_LOC;
                        end
                        smeu_pkg::OP_STL: begin
                            if (r_cnt == '0) begin
                                n_err = smeu_pkg::ERR_UNDER;
                            end else if (r_fcnt != '0) begin
                                n_state = S_LOC;
                            end else begin
                                n_cnt = cm1;
                                if (r_cnt > CW'(1)) n_state = S_TOSW;
                            end
                        end
                        smeu_pkg::OP_PUSHF: begin
                            if (r_fcnt >= FRM_FULL) begin
                                n_err = smeu_pkg::ERR_FRAMES;
                            end else if (loc_need > LOC_FULL) begin
                                n_err = smeu_pkg::ERR_LOCALS;
                            end else begin
                                fr_we  = 1'b1;
                                n_fcnt = r_fcnt + NW'(1);
                                n_zb   = r_used;
                                n_used = loc_need[UW-1:0];
                                n_k    = '0;
                                if (r_slot != '0) n_state = S_ZERO;
                            end
                        end
                        smeu_pkg::OP_PI8, smeu_pkg::OP_PI16, smeu_pkg::OP_PI32,
                        smeu_pkg::OP_PI64, smeu_pkg::OP_PSTR: begin
                            if (r_cnt == STK_FULL) begin
                                n_err = smeu_pkg::ERR_OVER;
                            end else begin
                                st_we = 1'b1;
                                st_wd = push_val;
                                n_tos = push_val;
                                n_cnt = r_cnt + CW'(1);
                            end
                        end
                        smeu_pkg::OP_JMP: begin
                            n_br = 1'b1;
                        end
                        smeu_pkg::OP_TRAP: begin
                            n_err = smeu_pkg::ERR_TRAP;
                        end
                        default: begin
                            if (r_op >= smeu_pkg::OP_ADD && r_op <= smeu_pkg::OP_GE) begin
                                if (r_cnt < CW'(2)) begin
                                    n_err = smeu_pkg::ERR_UNDER;
                                end else if ((r_op == smeu_pkg::OP_DIV ||
                                              r_op == smeu_pkg::OP_REM) && r_tos == '0) begin
                                    n_err = smeu_pkg::ERR_DIVZ;
                                end else begin
                                    n_state = S_BINW;
                                end
                            end else begin
                                n_err = smeu_pkg::ERR_BADOP;
                            end
                        end
                    endcase
                end
            end
            S_SWAP: begin
                st_we   = 1'b1;
                st_wa   = cm2[AW-1:0];
                n_b     = r_st_q;
                n_state = S_SWP2;
            end
            S_SWP2: begin
                st_we   = 1'b1;
                st_wa   = cm1[AW-1:0];
                st_wd   = r_b;
                n_tos   = r_b;
                n_state = S_OUT;
            end
            S_OVER: begin
                st_we   = 1'b1;
                st_wd   = r_st_q;
                n_tos   = r_st_q;
                n_cnt   = r_cnt + CW'(1);
                n_state = S_OUT;
            end
            S_ROT1: begin
                n_b     = r_st_q;
                st_ra   = cm3[AW-1:0];
                n_state = S_ROT2;
            end
            S_ROT2: begin
                n_c     = r_st_q;
                st_we   = 1'b1;
                st_wa   = cm3[AW-1:0];
                st_wd   = r_b;
                n_state = S_ROT3;
            end
            S_ROT3: begin
                st_we   = 1'b1;
                st_wa   = cm2[AW-1:0];
                n_state = S_ROT4;
            end
            S_ROT4: begin
                st_we   = 1'b1;
                st_wa   = cm1[AW-1:0];
                st_wd   = r_c;
                n_tos   = r_c;
                n_state = S_OUT;
            end
            S_BINW: begin
                n_b = r_st_q;
                if (r_op == smeu_pkg::OP_MUL) begin
                    n_acc   = '0;
                    n_p     = r_st_q;
                    n_q     = r_tos;
                    n_k     = '0;
                    n_state = S_MUL;
                end else if (r_op == smeu_pkg::OP_DIV || r_op == smeu_pkg::OP_REM) begin
                    n_state = S_DNB;
                end else begin
                    st_we   = 1'b1;
                    st_wa   = cm2[AW-1:0];
                    st_wd   = bin_res;
                    n_tos   = bin_res;
                    n_cnt   = cm1;
                    n_state = S_OUT;
                end
            end
            S_MUL: begin
                // Shift-add, one multiplier bit per cycle
                n_acc = add_s[DW-1:0];
                n_p   = r_p << 1;
                n_q   = r_q >> 1;
                n_k   = r_k + SW'(1);
                if (r_k == SW'(DW-1)) n_state = S_FIN;
            end
            S_DNB: begin
                n_sb    = r_b[DW-1];
                n_sa    = r_tos[DW-1];
                n_p     = r_b[DW-1] ? add_s[DW-1:0] : r_b;
                n_state = S_DNA;
            end
            S_DNA: begin
                n_q     = r_sa ? add_s[DW-1:0] : r_tos;
                n_acc   = '0;
                n_k     = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                // Restoring divide on magnitudes, one quotient bit per cycle
                n_p   = {r_p[DW-2:0], add_s[DW+1]};
                n_acc = add_s[DW+1] ? add_s[DW-1:0] : {r_acc[DW-2:0], r_p[DW-1]};
                n_k   = r_k + SW'(1);
                if (r_k == SW'(DW-1)) n_state = S_DFX;
            end
            S_DFX: begin
                n_acc   = dfx_neg ? add_s[DW-1:0] : dfx_val;
                n_state = S_FIN;
            end
            S_FIN: begin
                st_we   = 1'b1;
                st_wa   = cm2[AW-1:0];
                st_wd   = r_acc;
                n_tos   = r_acc;
                n_cnt   = cm1;
                n_state = S_OUT;
            end
            S_LOC: begin
                n_state = S_OUT;
                if (r_op == smeu_pkg::OP_POPF) begin
                    n_fcnt = r_fcnt - NW'(1);
                    n_used = r_used - UW'(r_fr_q.slots);
                end else if (r_slot >= r_fr_q.slots) begin
                    n_err = smeu_pkg::ERR_LOCAL;
                end else if (r_op == smeu_pkg::OP_LDL) begin
                    if (r_cnt == STK_FULL) n_err = smeu_pkg::ERR_OVER;
                    else n_state = S_LDW;
                end else begin
                    lc_we = 1'b1;
                    lc_wa = loc_addr[LW-1:0];
                    lc_wd = r_tos;
                    n_cnt = cm1;
                    if (r_cnt > CW'(1)) n_state = S_TOSW;
                end
            end
            S_LDW: begin
                st_we   = 1'b1;
                st_wd   = r_lc_q;
                n_tos   = r_lc_q;
                n_cnt   = r_cnt + CW'(1);
                n_state = S_OUT;
            end
            S_ZERO: begin
                // Clear one local of the new frame per cycle
                lc_we = 1'b1;
                lc_wa = LW'(r_zb + UW'(r_k));
                n_k   = r_k + SW'(1);
                if (r_k == r_slot - SW'(1)) begin
                    if (r_op == smeu_pkg::OP_ENTER && r_argc != '0) begin
                        n_k     = r_argc;
                        n_state = S_ENAR;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_ENAR: begin
                // Pop one argument into local k-1
                lc_we = 1'b1;
                lc_wa = LW'(r_k - SW'(1));
                n_k   = r_k - SW'(1);
                if (r_cnt == '0) begin
                    lc_wd = '0;
                    if (r_err == smeu_pkg::ERR_NONE) n_err = smeu_pkg::ERR_UNDER;
                    n_state = (r_k == SW'(1)) ? S_OUT : S_ENAR;
                end else begin
                    lc_wd = r_tos;
                    n_cnt = cm1;
                    if (r_cnt > CW'(1)) n_state = S_ENW;
                    else n_state = (r_k == SW'(1)) ? S_OUT : S_ENAR;
                end
            end
            S_ENW: begin
                n_tos   = r_st_q;
                n_state = (r_k == '0) ? S_OUT : S_ENAR;
            end
            S_TOSW: begin
                n_tos   = r_st_q;
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hold until the output register is free
                if (!r_mval || i_m_axis_tready) begin
                    n_mval  = 1'b1;
                    n_mdata = {r_err, r_br, r_cnt, ((r_cnt == '0) ? '0 : r_tos)};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // New top read after a pop lands at the old second entry
        if (r_state == S_ENAR) st_ra = cm2[AW-1:0];
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (st_we) st_mem[st_wa] <= st_wd;
        r_st_q <= st_mem[st_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lc_we) lc_mem[lc_wa] <= lc_wd;
        r_lc_q <= lc_mem[lc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fr_we) fr_mem[fr_wa] <= fr_wd;
        r_fr_q <= fr_mem[fr_ra];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_fcnt  <= '0;
            r_used  <= '0;
            r_err   <= smeu_pkg::ERR_NONE;
            r_mval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_fcnt  <= n_fcnt;
            r_used  <= n_used;
            r_err   <= n_err;
            r_mval  <= n_mval;
        end
    end

    // Payload and datapath
    always_ff @(posedge i_clk) begin
        r_op <= n_op;   r_imm <= n_imm;   r_slot <= n_slot; r_argc <= n_argc;
        r_br <= n_br;   r_tos <= n_tos;   r_b <= n_b;       r_c <= n_c;
        r_acc <= n_acc; r_p <= n_p;       r_q <= n_q;       r_sa <= n_sa;
        r_sb <= n_sb;   r_k <= n_k;       r_zb <= n_zb;     r_mdata <= n_mdata;
    end

    // Checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= STK_FULL) else $error("operand stack count beyond depth");

    a_frm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= FRM_FULL) else $error("frame count beyond depth");

    a_loc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_used} <= LOC_FULL) else $error("locals used beyond store");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_state == S_EXEC) else $error("accepted beat not executed");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != smeu_pkg::ERR_NONE && r_state != S_EXEC) |=> $stable(r_err))
        else $error("sticky error changed");

endmodule
